@@ hdl/lbpt_pkg.sv @@
// Shared types and constants for the LED blink pattern timer.
`timescale 1ns / 1ps
package lbpt_pkg;

  localparam int TIME_WIDTH = 32;
  localparam int FIELD_WIDTH = 32;
  localparam int CMP_WIDTH = (TIME_WIDTH > FIELD_WIDTH) ? TIME_WIDTH : FIELD_WIDTH;

  localparam logic [FIELD_WIDTH-1:0] FOREVER_DURATION = '1;
  localparam logic [FIELD_WIDTH-1:0] RESET_INTERVAL = FIELD_WIDTH'(250);

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  localparam logic [2:0] PAT_NONE        = 3'd0;
  localparam logic [2:0] PAT_SOLID_GREEN = 3'd1;
  localparam logic [2:0] PAT_SOLID_RED   = 3'd2;
  localparam logic [2:0] PAT_BOTH        = 3'd3;
  localparam logic [2:0] PAT_GREEN       = 3'd4;
  localparam logic [2:0] PAT_RED         = 3'd5;
  localparam logic [2:0] PAT_ALT         = 3'd6;

  typedef struct packed {
    logic [1:0]             op;
    logic [2:0]             pattern;
    logic [FIELD_WIDTH-1:0] run_length;
    logic [FIELD_WIDTH-1:0] blink_interval;
  } req_t;

  typedef struct packed {
    logic green_led;
    logic red_led;
    logic blinking;
  } leds_t;

endpackage

@@ hdl/lbpt_in_stage.sv @@
// Input register stage holding one accepted request.
`timescale 1ns / 1ps
module lbpt_in_stage
  import lbpt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  input  logic advance,
  output logic hold_valid,
  output req_t hold_req
);

  logic valid;
  req_t req;

  assign in_ready = !rst && (!valid || advance);
  assign hold_valid = valid;
  assign hold_req = req;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      req <= in_req;
    end
  end

endmodule

@@ hdl/lbpt_state.sv @@
// Timer and LED state with the single-pass update for one request.
`timescale 1ns / 1ps
module lbpt_state
  import lbpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  req_t  req,
  output leds_t result
);

  logic [TIME_WIDTH-1:0]  now_ms, now_ms_next;
  logic                   run_active, run_active_next;
  logic [2:0]             current_pattern, current_pattern_next;
  logic [TIME_WIDTH-1:0]  end_time, end_time_next;
  logic [FIELD_WIDTH-1:0] toggle_interval, toggle_interval_next;
  logic [TIME_WIDTH-1:0]  last_toggle_time, last_toggle_time_next;
  logic                   phase, phase_next;
  logic                   green_level, green_level_next;
  logic                   red_level, red_level_next;
  logic [TIME_WIDTH-1:0]  tick_time;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic                   expired;
  logic                   toggle_due;

  assign tick_time = now_ms + TIME_WIDTH'(1);
  assign elapsed = tick_time - last_toggle_time;
  assign expired = (end_time != '1) && (tick_time >= end_time);
  assign toggle_due = CMP_WIDTH'(elapsed) >= CMP_WIDTH'(toggle_interval);

  always_comb begin
    now_ms_next = now_ms;
    run_active_next = run_active;
    current_pattern_next = current_pattern;
    end_time_next = end_time;
    toggle_interval_next = toggle_interval;
    last_toggle_time_next = last_toggle_time;
    phase_next = phase;
    green_level_next = green_level;
    red_level_next = red_level;
    unique case (req.op)
      OP_TICK: begin
        now_ms_next = tick_time;
        if (run_active) begin
          if (expired) begin
            run_active_next = 1'b0;
            current_pattern_next = PAT_NONE;
            green_level_next = 1'b0;
            red_level_next = 1'b0;
          end else if (current_pattern == PAT_SOLID_GREEN) begin
            green_level_next = 1'b1;
            red_level_next = 1'b0;
          end else if (current_pattern == PAT_SOLID_RED) begin
            green_level_next = 1'b0;
            red_level_next = 1'b1;
          end else if (toggle_due) begin
            last_toggle_time_next = tick_time;
            phase_next = !phase;
            case (current_pattern)
              PAT_BOTH: begin
                green_level_next = !phase;
                red_level_next = !phase;
              end
              PAT_GREEN: begin
                green_level_next = !phase;
                red_level_next = 1'b0;
              end
              PAT_RED: begin
                green_level_next = 1'b0;
                red_level_next = !phase;
              end
              PAT_ALT: begin
                green_level_next = !phase;
                red_level_next = phase;
              end
              default: begin
              end
            endcase
          end
        end
      end
      OP_START: begin
        current_pattern_next = req.pattern;
        run_active_next = 1'b1;
        end_time_next = (req.run_length == FOREVER_DURATION) ? '1
                        : now_ms + TIME_WIDTH'(req.run_length);
        toggle_interval_next = req.blink_interval;
        last_toggle_time_next = '0;
        phase_next = 1'b0;
      end
      OP_STOP: begin
        run_active_next = 1'b0;
        current_pattern_next = PAT_NONE;
      end
      default: begin
      end
    endcase
  end

  assign result = '{green_led: green_level_next, red_led: red_level_next,
                    blinking: run_active_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms <= '0;
      run_active <= 1'b0;
      current_pattern <= PAT_NONE;
      end_time <= '0;
      toggle_interval <= RESET_INTERVAL;
      last_toggle_time <= '0;
      phase <= 1'b0;
      green_level <= 1'b0;
      red_level <= 1'b0;
    end else if (fire) begin
      now_ms <= now_ms_next;
      run_active <= run_active_next;
      current_pattern <= current_pattern_next;
      end_time <= end_time_next;
      toggle_interval <= toggle_interval_next;
      last_toggle_time <= last_toggle_time_next;
      phase <= phase_next;
      green_level <= green_level_next;
      red_level <= red_level_next;
    end
  end

  a_stop_clears_run: assert property (@(posedge clk) disable iff (rst)
    fire && req.op == OP_STOP |=> !run_active && current_pattern == PAT_NONE)
    else $error("stop request left the run active");

  a_start_arms_run: assert property (@(posedge clk) disable iff (rst)
    fire && req.op == OP_START |=> run_active && !phase && last_toggle_time == '0)
    else $error("start request did not arm the run");

  a_idle_tick_holds_leds: assert property (@(posedge clk) disable iff (rst)
    fire && req.op == OP_TICK && !run_active |=> $stable(green_level) && $stable(red_level))
    else $error("LED levels changed while no run was active");

  a_time_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    !(fire && req.op == OP_TICK) |=> $stable(now_ms))
    else $error("time advanced without a tick request");

endmodule

@@ hdl/lbpt_out_stage.sv @@
// Result register stage holding one finished result until taken.
`timescale 1ns / 1ps
module lbpt_out_stage
  import lbpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  leds_t res_in,
  output logic  free,
  output logic  out_valid,
  input  logic  out_ready,
  output leds_t res
);

  logic  valid;
  leds_t data;

  assign free = !valid || out_ready;
  assign out_valid = valid;
  assign res = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
    if (load) begin
      data <= res_in;
    end
  end

endmodule

@@ hdl/led_blink_pattern_timer_top.sv @@
// Top level of the LED blink pattern timer.
// One request a cycle is sustained: a request sits in the input register, the state update
// and LED levels are computed in one pass and land in the result register, so a result is
// offered once its request has passed the input and result registers; a result held by the receiver
// stalls the input register. Tick requests advance a 32-bit millisecond counter; start
// loads a pattern, run length (all ones runs forever) and toggle interval; stop ends the
// run. Each request returns the LED levels and run status after it.
`timescale 1ns / 1ps
module led_blink_pattern_timer_top
  import lbpt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             op,
  input  logic [2:0]             pattern,
  input  logic [FIELD_WIDTH-1:0] run_length,
  input  logic [FIELD_WIDTH-1:0] blink_interval,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   green_led,
  output logic                   red_led,
  output logic                   blinking
);

  req_t  in_req;
  req_t  hold_req;
  logic  hold_valid;
  logic  out_free;
  logic  advance;
  leds_t next_res;
  leds_t res;

  assign in_req = '{op: op, pattern: pattern, run_length: run_length,
                    blink_interval: blink_interval};
  assign advance = hold_valid && out_free;

  lbpt_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req     (in_req),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_req   (hold_req)
  );

  lbpt_state u_state (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .req    (hold_req),
    .result (next_res)
  );

  lbpt_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_in    (next_res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign green_led = res.green_led;
  assign red_led = res.red_led;
  assign blinking = res.blinking;

endmodule
